[rtl/bfp_pkg.sv]
// Shared types and constants for the beacon frame parser.
// Holds parse phases, field kinds, status codes and the result record.
// No dependencies; compile first.
`default_nettype none

package bfp_pkg;

	// depth of the result queue between decoder and output port
	localparam int OUT_DEPTH = 4;

	localparam int LIMIT_W     = 11;
	localparam int VALUE_W     = 64;
	localparam int BYTE_W      = 8;
	localparam int KIND_W      = 4;
	localparam int STATUS_W    = 2;
	localparam int LIMIT_RESET = 64;

	// service numbers that together mark a bloom filter block
	localparam logic [BYTE_W-1:0] HASH_SERVICE = 8'd126;
	localparam logic [BYTE_W-1:0] BITS_SERVICE = 8'd127;

	// presence flag bits
	localparam int FLAG_EID    = 0;
	localparam int FLAG_SVC    = 1;
	localparam int FLAG_PERIOD = 3;

	typedef enum logic [3:0] {
		PH_VERSION   = 4'd0,
		PH_FLAGS     = 4'd1,
		PH_SEQ_HI    = 4'd2,
		PH_SEQ_LO    = 4'd3,
		PH_EID_LEN   = 4'd4,
		PH_EID_BYTES = 4'd5,
		PH_SVC_COUNT = 4'd6,
		PH_SVC_NUM   = 4'd7,
		PH_SVC_LEN   = 4'd8,
		PH_SVC_BYTES = 4'd9,
		PH_PERIOD    = 4'd10,
		PH_DONE      = 4'd11
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		K_VERSION   = 4'd0,
		K_FLAGS     = 4'd1,
		K_SEQ       = 4'd2,
		K_EID_LEN   = 4'd3,
		K_EID_BYTE  = 4'd4,
		K_SVC_COUNT = 4'd5,
		K_SVC_NUM   = 4'd6,
		K_SVC_LEN   = 4'd7,
		K_SVC_BYTE  = 4'd8,
		K_PERIOD    = 4'd9,
		K_STATUS    = 4'd10
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_MAND     = 2'd1,
		ST_OPT      = 2'd2,
		ST_EID_LONG = 2'd3
	} status_t;

	typedef struct packed {
		kind_t               kind;
		logic [VALUE_W-1:0]  value;
		status_t             status;
		logic                filter;
		logic                last;
	} result_t;

	// results produced by one accepted byte, first result in r0
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

`default_nettype wire

[rtl/bfp_decode.sv]
// Byte-wise beacon decoder: parse state, SDNV accumulation and result build.
// Produces up to two results per accepted byte. Depends on bfp_pkg.
`default_nettype none

module bfp_decode (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [bfp_pkg::LIMIT_W-1:0]   cfg_wdata,
	input  wire logic                          in_fire,
	input  wire logic [bfp_pkg::BYTE_W-1:0]    data_byte,
	input  wire logic                          frame_end,
	output bfp_pkg::push_t                     push
);
	import bfp_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	phase_t             phase_q, phase_n;
	logic [VALUE_W-1:0] acc_q, acc_n;
	logic [VALUE_W-1:0] brem_q, brem_n;
	logic [VALUE_W-1:0] srem_q, srem_n;
	logic [3:0]         flags_q, flags_n;
	logic [BYTE_W-1:0]  seqhi_q, seqhi_n;
	status_t            fault_q, fault_n;
	logic               long_q, long_n;
	logic               hash_q, hash_n;
	logic               bits_q, bits_n;

	logic [VALUE_W-1:0] acc_shift;
	logic               sdnv_done;
	logic               len_long;
	status_t            end_fault;
	logic               fld_valid;
	kind_t              fld_kind;
	logic [VALUE_W-1:0] fld_value;
	result_t            fld_res, st_res;

	// shift one SDNV byte in; done when the continuation bit is clear
	assign acc_shift = {acc_q[VALUE_W-8:0], data_byte[6:0]};
	assign sdnv_done = ~data_byte[7];
	assign len_long  = (acc_shift[VALUE_W-1:LIMIT_W] != '0) ||
		(acc_shift[LIMIT_W-1:0] >= limit_q);

	// next parse state
	always_comb begin
		phase_n   = phase_q;
		acc_n     = acc_q;
		brem_n    = brem_q;
		srem_n    = srem_q;
		flags_n   = flags_q;
		seqhi_n   = seqhi_q;
		fault_n   = fault_q;
		long_n    = long_q;
		hash_n    = hash_q;
		bits_n    = bits_q;
		end_fault = fault_q;
		unique case (phase_q)
			PH_VERSION: begin
				acc_n   = '0;
				phase_n = PH_FLAGS;
			end
			PH_FLAGS: begin
				acc_n = acc_shift;
				if (sdnv_done) begin
					acc_n   = '0;
					flags_n = acc_shift[3:0];
					phase_n = PH_SEQ_HI;
				end
			end
			PH_SEQ_HI: begin
				seqhi_n = data_byte;
				phase_n = PH_SEQ_LO;
			end
			PH_SEQ_LO: begin
				if (flags_q[FLAG_EID])
					phase_n = PH_EID_LEN;
				else if (flags_q[FLAG_SVC])
					phase_n = PH_SVC_COUNT;
				else if (flags_q[FLAG_PERIOD] && fault_q == ST_OK)
					phase_n = PH_PERIOD;
				else
					phase_n = PH_DONE;
			end
			PH_EID_LEN: begin
				acc_n = acc_shift;
				if (sdnv_done) begin
					acc_n  = '0;
					brem_n = acc_shift;
					if (len_long) begin
						long_n = 1'b1;
						if (fault_q == ST_OK)
							fault_n = ST_EID_LONG;
					end
					if (acc_shift != '0)
						phase_n = PH_EID_BYTES;
					else if (flags_q[FLAG_SVC])
						phase_n = PH_SVC_COUNT;
					else if (flags_q[FLAG_PERIOD] && fault_n == ST_OK)
						phase_n = PH_PERIOD;
					else
						phase_n = PH_DONE;
				end
			end
			PH_EID_BYTES: begin
				brem_n = brem_q - VALUE_W'(1);
				if (brem_q == VALUE_W'(1)) begin
					if (flags_q[FLAG_SVC])
						phase_n = PH_SVC_COUNT;
					else if (flags_q[FLAG_PERIOD] && fault_q == ST_OK)
						phase_n = PH_PERIOD;
					else
						phase_n = PH_DONE;
				end
			end
			PH_SVC_COUNT: begin
				acc_n = acc_shift;
				if (sdnv_done) begin
					acc_n  = '0;
					srem_n = acc_shift;
					if (acc_shift != '0)
						phase_n = PH_SVC_NUM;
					else if (flags_q[FLAG_PERIOD] && fault_q == ST_OK)
						phase_n = PH_PERIOD;
					else
						phase_n = PH_DONE;
				end
			end
			PH_SVC_NUM: begin
				if (data_byte == HASH_SERVICE)
					hash_n = 1'b1;
				if (data_byte == BITS_SERVICE)
					bits_n = 1'b1;
				acc_n   = '0;
				phase_n = PH_SVC_LEN;
			end
			PH_SVC_LEN: begin
				acc_n = acc_shift;
				if (sdnv_done) begin
					acc_n  = '0;
					brem_n = acc_shift;
					if (acc_shift != '0) begin
						phase_n = PH_SVC_BYTES;
					end else begin
						srem_n = srem_q - VALUE_W'(1);
						if (srem_q != VALUE_W'(1))
							phase_n = PH_SVC_NUM;
						else if (flags_q[FLAG_PERIOD] && fault_q == ST_OK)
							phase_n = PH_PERIOD;
						else
							phase_n = PH_DONE;
					end
				end
			end
			PH_SVC_BYTES: begin
				brem_n = brem_q - VALUE_W'(1);
				if (brem_q == VALUE_W'(1)) begin
					srem_n = srem_q - VALUE_W'(1);
					if (srem_q != VALUE_W'(1))
						phase_n = PH_SVC_NUM;
					else if (flags_q[FLAG_PERIOD] && fault_q == ST_OK)
						phase_n = PH_PERIOD;
					else
						phase_n = PH_DONE;
				end
			end
			PH_PERIOD: begin
				acc_n = acc_shift;
				if (sdnv_done) begin
					acc_n   = '0;
					phase_n = PH_DONE;
				end
			end
			default: begin
				phase_n = PH_DONE;
			end
		endcase

		// frame end: record truncation unless a fault is already held, then clear
		if (frame_end) begin
			end_fault = fault_n;
			if (fault_n == ST_OK) begin
				if (phase_n <= PH_EID_BYTES)
					end_fault = ST_MAND;
				else if (phase_n <= PH_PERIOD)
					end_fault = ST_OPT;
			end
			phase_n = PH_VERSION;
			acc_n   = '0;
			brem_n  = '0;
			srem_n  = '0;
			flags_n = '0;
			seqhi_n = '0;
			fault_n = ST_OK;
			long_n  = 1'b0;
			hash_n  = 1'b0;
			bits_n  = 1'b0;
		end
	end

	// field result for this byte
	always_comb begin
		fld_valid = 1'b0;
		fld_kind  = K_VERSION;
		fld_value = {{(VALUE_W-BYTE_W){1'b0}}, data_byte};
		unique case (phase_q)
			PH_VERSION: begin
				fld_valid = 1'b1;
				fld_kind  = K_VERSION;
			end
			PH_FLAGS: begin
				fld_valid = sdnv_done;
				fld_kind  = K_FLAGS;
				fld_value = acc_shift;
			end
			PH_SEQ_LO: begin
				fld_valid = 1'b1;
				fld_kind  = K_SEQ;
				fld_value = {{(VALUE_W-2*BYTE_W){1'b0}}, seqhi_q, data_byte};
			end
			PH_EID_LEN: begin
				fld_valid = sdnv_done;
				fld_kind  = K_EID_LEN;
				fld_value = acc_shift;
			end
			PH_EID_BYTES: begin
				fld_valid = ~long_q;
				fld_kind  = K_EID_BYTE;
			end
			PH_SVC_COUNT: begin
				fld_valid = sdnv_done;
				fld_kind  = K_SVC_COUNT;
				fld_value = acc_shift;
			end
			PH_SVC_NUM: begin
				fld_valid = 1'b1;
				fld_kind  = K_SVC_NUM;
			end
			PH_SVC_LEN: begin
				fld_valid = sdnv_done;
				fld_kind  = K_SVC_LEN;
				fld_value = acc_shift;
			end
			PH_SVC_BYTES: begin
				fld_valid = 1'b1;
				fld_kind  = K_SVC_BYTE;
			end
			PH_PERIOD: begin
				fld_valid = sdnv_done;
				fld_kind  = K_PERIOD;
				fld_value = acc_shift;
			end
			default: begin
				fld_valid = 1'b0;
			end
		endcase
	end

	// build the result records; filter flag reflects this byte's update
	always_comb begin
		fld_res.kind   = fld_kind;
		fld_res.value  = fld_value;
		fld_res.status = ST_OK;
		fld_res.filter = (hash_q | (phase_q == PH_SVC_NUM && data_byte == HASH_SERVICE)) &
			(bits_q | (phase_q == PH_SVC_NUM && data_byte == BITS_SERVICE));
		fld_res.last   = 1'b0;
		st_res         = fld_res;
		st_res.kind    = K_STATUS;
		st_res.value   = '0;
		st_res.status  = end_fault;
		st_res.last    = 1'b1;

		push.r0  = fld_valid ? fld_res : st_res;
		push.r1  = st_res;
		push.cnt = in_fire ? ({1'b0, fld_valid} + {1'b0, frame_end}) : 2'd0;
	end

	// hold the limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_W'(LIMIT_RESET);
		end else if (cfg_wen) begin
			limit_q <= cfg_wdata;
		end
	end

	// advance parse state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VERSION;
			acc_q   <= '0;
			brem_q  <= '0;
			srem_q  <= '0;
			flags_q <= '0;
			seqhi_q <= '0;
			fault_q <= ST_OK;
			long_q  <= 1'b0;
			hash_q  <= 1'b0;
			bits_q  <= 1'b0;
		end else if (in_fire) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			brem_q  <= brem_n;
			srem_q  <= srem_n;
			flags_q <= flags_n;
			seqhi_q <= seqhi_n;
			fault_q <= fault_n;
			long_q  <= long_n;
			hash_q  <= hash_n;
			bits_q  <= bits_n;
		end
	end

endmodule

`default_nettype wire

[rtl/bfp_out_fifo.sv]
// Result queue: takes up to two results per cycle, hands out one per cycle when popped.
// Registered entries, head read at the read pointer. Depends on bfp_pkg.
`default_nettype none

module bfp_out_fifo #(
	parameter int DEPTH = bfp_pkg::OUT_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire bfp_pkg::push_t push,
	input  wire logic     pop,
	output bfp_pkg::result_t head,
	output logic          not_empty,
	output logic          room2
);
	import bfp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	result_t            entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q, wr_next, wr_after;
	logic [CNT_W-1:0]   cnt_q;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1))
			wrap_inc = '0;
		else
			wrap_inc = p + PTR_W'(1);
	endfunction

	assign wr_next   = wrap_inc(wr_q);
	assign wr_after  = wrap_inc(wr_next);
	assign head      = entry_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign room2     = (cnt_q <= CNT_W'(DEPTH - 2));

	// store incoming results
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			entry_q[wr_q] <= push.r0;
		if (push.cnt == 2'd2)
			entry_q[wr_next] <= push.r1;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			unique case (push.cnt)
				2'd2:    wr_q <= wr_after;
				2'd1:    wr_q <= wr_next;
				default: wr_q <= wr_q;
			endcase
			if (pop)
				rd_q <= wrap_inc(rd_q);
			cnt_q <= cnt_q + CNT_W'(push.cnt) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

[rtl/beacon_frame_parser.sv]
// Top level of the neighbor-discovery beacon parser.
// Instantiates bfp_decode and bfp_out_fifo; depends on bfp_pkg.
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+-----------------------------------------
//  s_        | in  | s_tvalid/s_tready | tdata: data_byte; tlast: frame_end
//  m_        | out | m_tvalid/m_tready | tdata: value,status,filter; tuser: kind;
//            |     |                  | tlast: last_of_frame
//  cfg_      | in  | cfg_wen          | cfg_wdata: eid_length_limit
//
// One byte is accepted per cycle while s_tready is high; its results are written
// into the queue at the accepting edge, so m_tvalid rises in the next cycle, and
// the queue hands out one result per cycle while m_tready is high. A byte yields
// at most two results (a field and the frame status), so s_tready holds low while
// the queue has fewer than two free entries. Reset clears parse state and the
// queue; the limit register returns to 64.
`default_nettype none

module beacon_frame_parser #(
	parameter int OUT_DEPTH = bfp_pkg::OUT_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wen,
	input  wire logic [bfp_pkg::LIMIT_W-1:0]  cfg_wdata,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [7:0]                   s_tdata,  // [7:0] data_byte
	input  wire logic                         s_tlast,  // frame_end
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [71:0]                       m_tdata,  // [63:0] field_value,
	                                                    // [65:64] frame_status,
	                                                    // [66] filter_present
	output logic [bfp_pkg::KIND_W-1:0]        m_tuser,  // [3:0] field_kind
	output logic                              m_tlast   // last_of_frame
);
	import bfp_pkg::*;

	push_t   push;
	result_t head;
	logic    in_fire;
	logic    room2;

	assign in_fire = s_tvalid & s_tready;
	assign s_tready = room2;

	bfp_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_fire   (in_fire),
		.data_byte (s_tdata),
		.frame_end (s_tlast),
		.push      (push)
	);

	bfp_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (m_tvalid & m_tready),
		.head      (head),
		.not_empty (m_tvalid),
		.room2     (room2)
	);

	// drive the result request from the queue head
	assign m_tdata = {5'd0, head.filter, head.status, head.value};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

`default_nettype wire

[verif/tb_beacon_frame_parser.sv]
`timescale 1ns / 100ps
// Self-checking testbench for beacon_frame_parser: streams directed and random beacon
// frames, predicts every decoded field in a scoreboard class and checks the output stream.
// Depends on bfp_pkg and the beacon_frame_parser RTL.

module tb_beacon_frame_parser;
	import bfp_pkg::*;

	localparam int WATCHDOG_LIMIT    = 5000;
	localparam int DRAIN_CYCLES      = 6;
	localparam int BYTES_PER_SETTING = 150;
	localparam int NUM_SETTINGS      = 8;

	// Predicts decoded fields per accepted byte and checks them in arrival order.
	class beacon_field_board;
		logic [LIMIT_W-1:0] eid_limit;
		phase_t             phase;
		logic [63:0]        acc;
		logic [63:0]        bytes_left;
		logic [63:0]        svc_left;
		logic [3:0]         flags;
		logic [7:0]         seq_hi;
		status_t            fault;
		bit                 eid_skip;
		bit                 seen_hash;
		bit                 seen_bits;
		result_t            expected_fields[$];
		int                 mismatches;

		function new();
			eid_limit = LIMIT_W'(LIMIT_RESET);
			mismatches = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			phase = PH_VERSION;
			acc = '0;
			bytes_left = '0;
			svc_left = '0;
			flags = '0;
			seq_hi = '0;
			fault = ST_OK;
			eid_skip = 0;
			seen_hash = 0;
			seen_bits = 0;
		endfunction

		function void emit(kind_t k, logic [63:0] v, status_t st, bit is_end);
			result_t r;
			r.kind = k;
			r.value = v;
			r.status = st;
			r.filter = seen_hash & seen_bits;
			r.last = is_end;
			expected_fields.push_back(r);
		endfunction

		// keep the first fault of the frame
		function void set_fault(status_t code);
			if (fault == ST_OK)
				fault = code;
		endfunction

		function void after_services();
			if (flags[FLAG_PERIOD] && fault == ST_OK)
				phase = PH_PERIOD;
			else
				phase = PH_DONE;
		endfunction

		function void after_eid();
			if (flags[FLAG_SVC])
				phase = PH_SVC_COUNT;
			else
				after_services();
		endfunction

		function void service_done();
			svc_left = svc_left - 64'd1;
			if (svc_left == 0)
				after_services();
			else
				phase = PH_SVC_NUM;
		endfunction

		// shift one SDNV group in; report whether the value is complete
		function bit shift_sdnv(logic [7:0] b);
			acc = {acc[56:0], b[6:0]};
			return !b[7];
		endfunction

		function void take_byte(logic [7:0] b, bit is_end);
			logic [63:0] v;
			case (phase)
				PH_VERSION: begin
					emit(K_VERSION, 64'(b), ST_OK, 0);
					phase = PH_FLAGS;
					acc = '0;
				end
				PH_FLAGS: begin
					if (shift_sdnv(b)) begin
						v = acc;
						acc = '0;
						flags = v[3:0];
						emit(K_FLAGS, v, ST_OK, 0);
						phase = PH_SEQ_HI;
					end
				end
				PH_SEQ_HI: begin
					seq_hi = b;
					phase = PH_SEQ_LO;
				end
				PH_SEQ_LO: begin
					emit(K_SEQ, 64'({seq_hi, b}), ST_OK, 0);
					if (flags[FLAG_EID])
						phase = PH_EID_LEN;
					else
						after_eid();
				end
				PH_EID_LEN: begin
					if (shift_sdnv(b)) begin
						v = acc;
						acc = '0;
						emit(K_EID_LEN, v, ST_OK, 0);
						if (v >= 64'(eid_limit)) begin
							eid_skip = 1;
							set_fault(ST_EID_LONG);
						end
						bytes_left = v;
						if (v == 0)
							after_eid();
						else
							phase = PH_EID_BYTES;
					end
				end
				PH_EID_BYTES: begin
					if (!eid_skip)
						emit(K_EID_BYTE, 64'(b), ST_OK, 0);
					bytes_left = bytes_left - 64'd1;
					if (bytes_left == 0)
						after_eid();
				end
				PH_SVC_COUNT: begin
					if (shift_sdnv(b)) begin
						v = acc;
						acc = '0;
						emit(K_SVC_COUNT, v, ST_OK, 0);
						svc_left = v;
						if (v == 0)
							after_services();
						else
							phase = PH_SVC_NUM;
					end
				end
				PH_SVC_NUM: begin
					if (b == HASH_SERVICE)
						seen_hash = 1;
					if (b == BITS_SERVICE)
						seen_bits = 1;
					emit(K_SVC_NUM, 64'(b), ST_OK, 0);
					acc = '0;
					phase = PH_SVC_LEN;
				end
				PH_SVC_LEN: begin
					if (shift_sdnv(b)) begin
						v = acc;
						acc = '0;
						emit(K_SVC_LEN, v, ST_OK, 0);
						bytes_left = v;
						if (v == 0)
							service_done();
						else
							phase = PH_SVC_BYTES;
					end
				end
				PH_SVC_BYTES: begin
					emit(K_SVC_BYTE, 64'(b), ST_OK, 0);
					bytes_left = bytes_left - 64'd1;
					if (bytes_left == 0)
						service_done();
				end
				PH_PERIOD: begin
					if (shift_sdnv(b)) begin
						v = acc;
						acc = '0;
						emit(K_PERIOD, v, ST_OK, 0);
						phase = PH_DONE;
					end
				end
				default: begin
					phase = PH_DONE;
				end
			endcase

			// close the frame with its status
			if (is_end) begin
				if (phase <= PH_EID_BYTES)
					set_fault(ST_MAND);
				else if (phase <= PH_PERIOD)
					set_fault(ST_OPT);
				emit(K_STATUS, '0, fault, 1);
				clear_frame();
			end
		endfunction

		function void check_field(result_t got);
			result_t want;
			if (expected_fields.size() == 0) begin
				$error("unexpected field: kind %0d value %0h", got.kind, got.value);
				mismatches++;
				return;
			end
			want = expected_fields.pop_front();
			if (got.kind !== want.kind) begin
				$error("field_kind: expected %0d, got %0d", want.kind, got.kind);
				mismatches++;
			end
			if (got.value !== want.value) begin
				$error("field_value: expected %0h, got %0h", want.value, got.value);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("frame_status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.filter !== want.filter) begin
				$error("filter_present: expected %0b, got %0b", want.filter, got.filter);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last_of_frame: expected %0b, got %0b", want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [LIMIT_W-1:0] cfg_wdata;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;   // [7:0] data_byte
	logic               s_tlast;   // frame_end
	logic               m_tvalid;
	logic               m_tready;
	logic [71:0]        m_tdata;   // [63:0] field_value, [65:64] frame_status,
	                               // [66] filter_present
	logic [KIND_W-1:0]  m_tuser;   // [3:0] field_kind
	logic               m_tlast;   // last_of_frame

	beacon_field_board board;
	result_t           out_field;
	logic [7:0]        frame_bytes[$];
	int                sent_count = 0;
	int                idle_cycles = 0;
	int                ready_hold = 0;
	int                stall_len;

	beacon_frame_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int ready_run();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(100, 300);
		return $urandom_range(0, 15);
	endfunction

	// toggle the result side between ready runs and stalls
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if (m_tready) begin
			stall_len = pick_gap();
			if (stall_len > 0) begin
				m_tready <= 1'b0;
				ready_hold = stall_len - 1;
			end else begin
				ready_hold = ready_run();
			end
		end else begin
			m_tready <= 1'b1;
			ready_hold = ready_run();
		end
	end

	// check results first, then note the new request; watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				out_field.kind = kind_t'(m_tuser);
				out_field.value = m_tdata[63:0];
				out_field.status = status_t'(m_tdata[65:64]);
				out_field.filter = m_tdata[66];
				out_field.last = m_tlast;
				board.check_field(out_field);
			end
			if (s_tvalid && s_tready)
				board.take_byte(s_tdata, s_tlast);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic logic [63:0] rand_wide();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r >> $urandom_range(0, 63);
	endfunction

	// append an SDNV, optionally with extra leading groups (zero or random)
	function automatic void add_sdnv(logic [63:0] v, int pad, bit junk);
		logic [69:0] w;
		logic [6:0]  grp;
		int          n;
		int          i;
		w = {6'd0, v};
		n = 1;
		while (n < 10 && (w >> (7 * n)) != 0)
			n++;
		for (i = n + pad - 1; i >= 0; i--) begin
			if (i >= n)
				grp = junk ? 7'($urandom) : 7'd0;
			else
				grp = w[7 * i +: 7];
			frame_bytes.push_back({i != 0, grp});
		end
	endfunction

	function automatic void add_random_bytes(int n);
		repeat (n)
			frame_bytes.push_back(8'($urandom));
	endfunction

	// build one beacon: mostly well formed, some truncated or pure noise
	function automatic void build_frame(logic [LIMIT_W-1:0] lim);
		logic [63:0] fl;
		logic [63:0] len;
		logic [63:0] cnt;
		int          r;
		int          i;
		int          nsvc;
		int          cut;
		bit          stop;
		frame_bytes.delete();
		stop = 0;
		frame_bytes.push_back(8'($urandom));
		fl = ($urandom_range(0, 9) == 0) ? rand_wide() : 64'($urandom_range(0, 15));
		add_sdnv(fl, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0, 1);
		add_random_bytes(2);

		if (fl[FLAG_EID]) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				len = 64'($urandom_range(0, 6));
			else if (r < 70)
				len = 64'(lim) + 64'($urandom_range(0, 2)) - 64'd1;
			else if (r < 85)
				len = rand_wide();
			else
				len = 64'($urandom_range(0, 20));
			add_sdnv(len, ($urandom_range(0, 9) == 0) ? 1 : 0, 0);
			if (len > 48) begin
				add_random_bytes($urandom_range(0, 5));
				stop = 1;
			end else begin
				add_random_bytes(int'(len));
			end
		end

		if (!stop && fl[FLAG_SVC]) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				cnt = 64'($urandom_range(0, 3));
			else if (r < 90)
				cnt = rand_wide();
			else
				cnt = 64'($urandom_range(4, 8));
			add_sdnv(cnt, ($urandom_range(0, 9) == 0) ? 1 : 0, 0);
			if (cnt > 6) begin
				nsvc = $urandom_range(0, 3);
				stop = 1;
			end else begin
				nsvc = int'(cnt);
			end
			for (i = 0; i < nsvc; i++) begin
				r = $urandom_range(0, 99);
				if (r < 30)
					frame_bytes.push_back(HASH_SERVICE);
				else if (r < 60)
					frame_bytes.push_back(BITS_SERVICE);
				else
					frame_bytes.push_back(8'($urandom));
				len = 64'(($urandom_range(0, 9) == 0) ?
					$urandom_range(5, 24) : $urandom_range(0, 4));
				add_sdnv(len, ($urandom_range(0, 9) == 0) ? 1 : 0, 0);
				add_random_bytes(int'(len));
			end
		end

		if (!stop && fl[FLAG_PERIOD]) begin
			// occasionally leave the period SDNV unterminated
			if ($urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(1, 12))
					frame_bytes.push_back(8'h80 | 8'($urandom));
				stop = 1;
			end else begin
				add_sdnv(rand_wide(), ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0, 1);
			end
		end

		if (!stop)
			add_random_bytes($urandom_range(0, 2));

		// break some frames short, replace a few with noise
		r = $urandom_range(0, 99);
		if (r < 12 && frame_bytes.size() > 1) begin
			cut = $urandom_range(1, frame_bytes.size() - 1);
			while (frame_bytes.size() > cut)
				void'(frame_bytes.pop_back());
		end else if (r < 16) begin
			frame_bytes.delete();
			add_random_bytes($urandom_range(1, 8));
		end
	endfunction

	task automatic send_byte(logic [7:0] b, bit is_end, bit calm);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= is_end;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_count++;
	endtask

	// send the frame, marking its final byte
	task automatic send_frame(bit calm);
		int i;
		for (i = 0; i < frame_bytes.size(); i++)
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1, calm);
	endtask

	task automatic run_random(int n);
		int start;
		start = sent_count;
		while (sent_count - start < n) begin
			build_frame(board.eid_limit);
			send_frame($urandom_range(0, 7) == 0);
		end
	endtask

	// drop valid, let the last request reach the scoreboard, then wait out
	// every pending field and the pipeline tail
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.expected_fields.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] v);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		board.eid_limit = v;
	endtask

	task automatic run_directed();
		// version only, truncated in the mandatory part
		frame_bytes = {8'h00};
		send_frame(0);
		// full frame: EID, zero-length hash service, bits service, period, trailing byte
		frame_bytes = {8'hFF, 8'h0B, 8'hAB, 8'hCD, 8'h01, 8'h61, 8'h02, 8'h7E, 8'h00,
			8'h7F, 8'h01, 8'h55, 8'h81, 8'h00, 8'h77};
		send_frame(0);
		// two-byte flags, over-long EID cut short: the EID fault wins, period suppressed
		frame_bytes = {8'h01, 8'h89, 8'h09, 8'h00, 8'h00, 8'h81, 8'h00, 8'h5A, 8'hA5};
		send_frame(0);
		// period expected but frame ends after the sequence number
		frame_bytes = {8'h7F, 8'h08, 8'h12, 8'h34};
		send_frame(0);
	endtask

	initial begin
		logic [LIMIT_W-1:0] settings[NUM_SETTINGS];
		int                 s;
		board = new();
		settings = '{11'd64, 11'd2, 11'd0, 11'd1, 11'd1024, 11'd2047, 11'd64, 11'd5};
		settings[6] = LIMIT_W'($urandom_range(1, 1024));
		arst_n <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		m_tready <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit first, then each further setting between idle points
		run_directed();
		for (s = 0; s < NUM_SETTINGS; s++) begin
			if (s > 0) begin
				settle();
				write_limit(settings[s]);
			end
			run_random(BYTES_PER_SETTING);
		end
		settle();

		if (board.mismatches == 0 && board.expected_fields.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
